/* design/dual_schmitt_spike_peak_detector_defines.svh */
// Assertion macros for the dual Schmitt spike peak detector.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef DUAL_SCHMITT_SPIKE_PEAK_DETECTOR_DEFINES_SVH
`define DUAL_SCHMITT_SPIKE_PEAK_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

`define DSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define DSSP_ASSERT_NEVER(lbl, cond, msg) \
  `DSSP_ASSERT(lbl, !(cond), msg)

`else

`define DSSP_ASSERT(lbl, prop, msg)

`define DSSP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* design/dssp_pkg.sv */
// Shared types and constants for the dual Schmitt spike peak detector.
// No dependencies.
package dssp_pkg;

  localparam int ChanW   = 2;
  localparam int SampleW = 16;
  localparam int ThrW    = 15;
  localparam int IndexW  = 32;

  localparam logic PolPos = 1'b0;
  localparam logic PolNeg = 1'b1;

  // What one trigger reports for the sample under evaluation
  typedef struct packed {
    logic               fire;
    logic [SampleW-1:0] value;
    logic [IndexW-1:0]  index;
  } trig_res_t;

endpackage

/* design/dssp_trigger.sv */
// One Schmitt trigger per channel with peak tracking (either polarity).
// Depends on dssp_pkg.
module dssp_trigger import dssp_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pol_i,
  input  logic               en_i,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ch_idx_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [ThrW-1:0]    thr_i,
  input  logic [IndexW-1:0]  count_i,
  output trig_res_t          res_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] armed_q;
  logic [SampleW-1:0]  peak_q [CHANNELS];
  logic [IndexW-1:0]   at_q   [CHANNELS];

  logic signed [SampleW-1:0] s;
  logic signed [SampleW-1:0] thr_pos;
  logic signed [SampleW-1:0] thr_neg;
  logic signed [SampleW-1:0] peak;
  logic                      armed;
  logic                      arm;
  logic                      disarm;
  logic                      better;
  logic                      load_peak;

  assign s       = $signed(sample_i);
  assign thr_pos = $signed({1'b0, thr_i});
  assign thr_neg = -thr_pos;
  assign armed   = armed_q[ch_idx_i];
  assign peak    = $signed(peak_q[ch_idx_i]);

  always_comb begin
    if (pol_i == PolNeg) begin
      arm    = s < thr_neg;
      disarm = s > 16'sd0;
      better = s < peak;
    end else begin
      arm    = s > thr_pos;
      disarm = s < 16'sd0;
      better = s > peak;
    end
  end

  // Arming sample seeds the peak; strict compare keeps the earliest index on ties
  assign load_peak = en_i & ((!armed & arm) | (armed & !disarm & better));

  assign res_o.fire  = armed & disarm;
  assign res_o.value = peak_q[ch_idx_i];
  assign res_o.index = at_q[ch_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (en_i) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (ch_idx_i == ChIdxW'(c)) begin
          if (!armed) begin
            armed_q[c] <= arm;
          end else if (disarm) begin
            armed_q[c] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (load_peak && ch_idx_i == ChIdxW'(c)) begin
        peak_q[c] <= sample_i;
        at_q[c]   <= count_i;
      end
    end
  end

endmodule

/* design/dual_schmitt_spike_peak_detector.sv */
// Dual Schmitt spike peak detector, top level. Depends on dssp_pkg, dssp_trigger.
// Input register -> trigger evaluation -> result register.
`include "dual_schmitt_spike_peak_detector_defines.svh"

// Takes one sample per clock, tagged with its channel, unless a result waits on
// a full output register, a rate set by the read-modify-write of the per-channel
// trigger state; each channel runs a positive and a negative Schmitt trigger
// that report the peak value and the per-channel sample index when they disarm.
// A result is written to the output register as its sample leaves the input
// register. Samples on a channel number of CHANNELS or above are dropped.
// The output register holds a result until taken; while it is full, a sample
// that produces no result still passes, and one that does waits. The
// threshold may be written only while no transaction is in flight.
module dual_schmitt_spike_peak_detector import dssp_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ThrW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ChanW-1:0]   channel_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ChanW-1:0]   spike_channel_o,
  output logic               polarity_o,
  output logic [SampleW-1:0] peak_value_o,
  output logic [IndexW-1:0]  peak_index_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ThrW-1:0]    thr_q;
  logic               s1_valid_q, s1_valid_d;
  logic [ChanW-1:0]   s1_ch_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [IndexW-1:0]  cnt_q [CHANNELS];
  logic               out_valid_q, out_valid_d;
  logic [ChanW-1:0]   out_ch_q;
  logic               out_pol_q;
  logic [SampleW-1:0] out_value_q;
  logic [IndexW-1:0]  out_index_q;

  logic              in_range;
  logic [ChIdxW-1:0] ch_idx;
  logic [IndexW-1:0] count;
  logic              fire_any;
  logic              out_free;
  logic              advance;
  logic              upd;
  trig_res_t         pos_res, neg_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  assign in_range = 32'(s1_ch_q) < CHANNELS;
  assign ch_idx   = ChIdxW'(s1_ch_q);
  assign count    = cnt_q[ch_idx];

  assign fire_any   = in_range & (pos_res.fire | neg_res.fire);
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q & (!fire_any | out_free);
  assign upd        = advance & in_range;
  assign in_ready_o = !s1_valid_q || advance;

  assign s1_valid_d = (in_valid_i & in_ready_o) | (s1_valid_q & !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_ch_q     <= channel_i;
      s1_sample_q <= sample_i;
    end
  end

  dssp_trigger #(.CHANNELS(CHANNELS)) u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pol_i    (PolPos),
    .en_i     (upd),
    .ch_idx_i (ch_idx),
    .sample_i (s1_sample_q),
    .thr_i    (thr_q),
    .count_i  (count),
    .res_o    (pos_res)
  );

  dssp_trigger #(.CHANNELS(CHANNELS)) u_neg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pol_i    (PolNeg),
    .en_i     (upd),
    .ch_idx_i (ch_idx),
    .sample_i (s1_sample_q),
    .thr_i    (thr_q),
    .count_i  (count),
    .res_o    (neg_res)
  );

  // Per-channel sample index, wraps at 2^32
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_q[c] <= '0;
      end
    end else if (upd) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (ch_idx == ChIdxW'(c)) begin
          cnt_q[c] <= count + 32'd1;
        end
      end
    end
  end

  assign out_valid_d = out_free ? (advance & fire_any) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The two triggers never fire on the same sample
  always_ff @(posedge clk_i) begin
    if (advance && fire_any) begin
      out_ch_q <= s1_ch_q;
      if (pos_res.fire) begin
        out_pol_q   <= PolPos;
        out_value_q <= pos_res.value;
        out_index_q <= pos_res.index;
      end else begin
        out_pol_q   <= PolNeg;
        out_value_q <= neg_res.value;
        out_index_q <= neg_res.index;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign spike_channel_o = out_ch_q;
  assign polarity_o      = out_pol_q;
  assign peak_value_o    = out_value_q;
  assign peak_index_o    = out_index_q;

  `DSSP_ASSERT_NEVER(a_single_fire,
    s1_valid_q && in_range && pos_res.fire && neg_res.fire,
    "both triggers fired on one sample")
  `DSSP_ASSERT(a_stall_blocks_input,
    (s1_valid_q && fire_any && !out_free) |-> !in_ready_o,
    "input accepted while a result is blocked")
  `DSSP_ASSERT(a_peak_sign,
    out_valid_o |-> ((polarity_o == PolPos) ? ($signed(peak_value_o) > 16'sd0)
                                            : ($signed(peak_value_o) < 16'sd0)),
    "peak sign disagrees with polarity")

endmodule
